// ===== rtl/kvs_pkg.sv =====
`timescale 1ns / 1ps

package kvs_pkg;

  localparam int KVS_CAPACITY = 64;
  localparam int KEY_W        = 32;
  localparam int VALUE_W      = 32;
  localparam int MODE_W       = 2;
  localparam int SLOT_W       = 6;
  localparam int STATUS_W     = 2;
  localparam int LIVE_W       = 7;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic                      occ;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } kvs_rec_t;

  typedef struct packed {
    logic hit;
    logic free;
  } kvs_match_t;

endpackage

// ===== rtl/kvs_store.sv =====
`timescale 1ns / 1ps

module kvs_store #(
  parameter int CAPACITY = kvs_pkg::KVS_CAPACITY,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [IW-1:0]     rd_addr,
  output kvs_pkg::kvs_rec_t rd_data,
  input  logic              wr_en,
  input  logic [IW-1:0]     wr_addr,
  input  kvs_pkg::kvs_rec_t wr_data
);
  import kvs_pkg::*;

  kvs_rec_t mem [CAPACITY];
  kvs_rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/kvs_match.sv =====
`timescale 1ns / 1ps

module kvs_match (
  input  kvs_pkg::kvs_rec_t   rec,
  input  logic signed [31:0]  key,
  output kvs_pkg::kvs_match_t res
);
  import kvs_pkg::*;

  always_comb begin
    res.hit  = rec.occ && (rec.key == key);
    res.free = !rec.occ;
  end

endmodule

// ===== rtl/key_value_slot_table.sv =====
// Key/value slot table searched by linear scan. An item (insert, remove or
// search) is taken when start is high and busy is low; busy then stays high
// while one shared compare unit walks the slots below the high-water mark,
// one slot read per cycle from the slot memory, stopping at the first match.
// A request passes through the scan state, whose slot reads are registered,
// and then the write-back state before busy drops; the result appears for one
// cycle on out_valid right after busy drops. Results cannot be held off, so
// the receiver must take every out_valid cycle. Only slots below the
// high-water mark are ever read, so the slot memory needs no clearing after
// reset.
`timescale 1ns / 1ps

module key_value_slot_table #(
  parameter int CAPACITY = kvs_pkg::KVS_CAPACITY
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [kvs_pkg::MODE_W-1:0]    in_mode,
  input  logic signed [kvs_pkg::KEY_W-1:0]     in_key,
  input  logic signed [kvs_pkg::VALUE_W-1:0]   in_value,
  output logic                                 out_valid,
  output logic        [kvs_pkg::SLOT_W-1:0]    out_slot,
  output logic        [kvs_pkg::STATUS_W-1:0]  out_status,
  output logic signed [kvs_pkg::VALUE_W-1:0]   out_stored_value,
  output logic        [kvs_pkg::LIVE_W-1:0]    out_live_count
);
  import kvs_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic [CW-1:0] hw_r, hw_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          rv_r, rv_nxt;
  logic [IW-1:0] rtag_r, rtag_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] fidx_r, fidx_nxt;
  logic signed [VALUE_W-1:0] fval_r, fval_nxt;
  logic          free_r, free_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;

  logic        [MODE_W-1:0]  mode_r, mode_nxt;
  logic signed [KEY_W-1:0]   key_r, key_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [IW-1:0]              slot_r, slot_nxt;
  logic [STATUS_W-1:0]        status_r, status_nxt;
  logic signed [VALUE_W-1:0]  stored_r, stored_nxt;
  logic [CW-1:0]              live_r, live_nxt;

  logic          accept;
  logic          issue;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  kvs_rec_t      rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  kvs_rec_t      wr_data;
  kvs_match_t    m;

  kvs_store #(.CAPACITY(CAPACITY)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  kvs_match u_match (
    .rec (rd_data),
    .key (key_r),
    .res (m)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign issue  = (state_r == S_SCAN) && (iss_r < hw_r);
  assign rd_en   = issue;
  assign rd_addr = iss_r[IW-1:0];

  always_comb begin
    state_nxt     = state_r;
    hw_nxt        = hw_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    rv_nxt        = 1'b0;
    rtag_nxt      = rtag_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    fval_nxt      = fval_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    out_valid_nxt = 1'b0;
    slot_nxt      = slot_r;
    status_nxt    = status_r;
    stored_nxt    = stored_r;
    live_nxt      = live_r;
    wr_en         = 1'b0;
    wr_addr       = fidx_r;
    wr_data       = '{occ: 1'b1, key: key_r, value: value_r};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt  = in_mode;
          key_nxt   = in_key;
          value_nxt = in_value;
          iss_nxt   = '0;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          iss_nxt  = iss_r + CW'(1);
          rv_nxt   = 1'b1;
          rtag_nxt = iss_r[IW-1:0];
        end
        if (rv_r) begin
          if (m.hit) begin
            found_nxt = 1'b1;
            fidx_nxt  = rtag_r;
            fval_nxt  = rd_data.value;
          end else if (m.free && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rtag_r;
          end
        end
        if ((rv_r && m.hit) || !issue) begin
          rv_nxt    = 1'b0;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_DONE;
        stored_nxt    = '0;
        slot_nxt      = '0;
        case (mode_r)
          MODE_INSERT: begin
            stored_nxt = value_r;
            if (found_r) begin
              wr_en    = 1'b1;
              wr_addr  = fidx_r;
              slot_nxt = fidx_r;
            end else if (free_r) begin
              wr_en    = 1'b1;
              wr_addr  = free_idx_r;
              slot_nxt = free_idx_r;
              cnt_nxt  = cnt_r + CW'(1);
            end else if (hw_r < CW'(CAPACITY)) begin
              wr_en    = 1'b1;
              wr_addr  = hw_r[IW-1:0];
              slot_nxt = hw_r[IW-1:0];
              hw_nxt   = hw_r + CW'(1);
              cnt_nxt  = cnt_r + CW'(1);
            end else begin
              stored_nxt = '0;
              status_nxt = ST_FULL;
            end
          end
          MODE_REMOVE: begin
            if (found_r) begin
              wr_en    = 1'b1;
              wr_addr  = fidx_r;
              wr_data  = '{occ: 1'b0, key: key_r, value: value_r};
              slot_nxt = fidx_r;
              cnt_nxt  = cnt_r - CW'(1);
            end else begin
              status_nxt = ST_MISS;
            end
          end
          default: begin
            if (found_r) begin
              slot_nxt   = fidx_r;
              stored_nxt = fval_r;
            end else begin
              status_nxt = ST_MISS;
            end
          end
        endcase
        live_nxt  = cnt_nxt;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hw_r        <= '0;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r      <= iss_nxt;
    rtag_r     <= rtag_nxt;
    found_r    <= found_nxt;
    fidx_r     <= fidx_nxt;
    fval_r     <= fval_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    value_r    <= value_nxt;
    slot_r     <= slot_nxt;
    status_r   <= status_nxt;
    stored_r   <= stored_nxt;
    live_r     <= live_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_slot         = SLOT_W'(slot_r);
  assign out_status       = status_r;
  assign out_stored_value = stored_r;
  assign out_live_count   = LIVE_W'(live_r);

`ifndef SYNTHESIS
  a_cnt_below_hw: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= hw_r)
    else $error("live count above high-water mark");

  a_hw_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(wr_en)) |-> $stable(hw_r))
    else $error("high-water mark moved without a write");

  a_result_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_WRITE))
    else $error("result without write-back cycle");

  a_full_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_FULL)) |-> (hw_r == CW'(CAPACITY)))
    else $error("full status below capacity");

  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN))
    else $error("accepted item did not start a scan");
`endif

endmodule

// ===== verif/tb_key_value_slot_table.sv =====
`timescale 1ns / 1ps

module tb_key_value_slot_table;
  import kvs_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int POOL_SIZE = 96;
  localparam int ROUNDS = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [SLOT_W-1:0]         slot;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] stored;
    logic [LIVE_W-1:0]         live;
  } lookup_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [MODE_W-1:0] in_mode = '0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic busy;
  logic out_valid;
  logic [SLOT_W-1:0] out_slot;
  logic [STATUS_W-1:0] out_status;
  logic signed [VALUE_W-1:0] out_stored_value;
  logic [LIVE_W-1:0] out_live_count;

  request_t pending_reqs[$];
  lookup_t expected_results[$];

  logic signed [KEY_W-1:0] tbl_key[KVS_CAPACITY];
  logic signed [VALUE_W-1:0] tbl_value[KVS_CAPACITY];
  bit tbl_occ[KVS_CAPACITY];
  int fill_mark = 0;
  int live_cnt = 0;

  int drv_sent = 0;
  int fail_count = 0;
  int checked = 0;
  int stall_cycles = 0;
  int n_insert = 0, n_remove = 0, n_search = 0, n_spare = 0;
  int n_full = 0, n_miss = 0, peak_live = 0;

  key_value_slot_table i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_key           (in_key),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_slot         (out_slot),
    .out_status       (out_status),
    .out_stored_value (out_stored_value),
    .out_live_count   (out_live_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lookup_t predict_lookup(logic [MODE_W-1:0] mode,
                                             logic signed [KEY_W-1:0] key,
                                             logic signed [VALUE_W-1:0] value);
    lookup_t r;
    int hit;
    int hole;
    int i;
    r = '0;
    hit = -1;
    hole = -1;
    for (i = 0; i < fill_mark; i++) begin
      if (tbl_occ[i] && tbl_key[i] == key && hit < 0) hit = i;
      if (!tbl_occ[i] && hole < 0) hole = i;
    end
    case (mode)
      MODE_INSERT: begin
        n_insert++;
        if (hit >= 0) begin
          tbl_value[hit] = value;
          r.slot = hit[SLOT_W-1:0];
          r.stored = value;
        end else if (hole >= 0 || fill_mark < KVS_CAPACITY) begin
          if (hole < 0) begin
            hole = fill_mark;
            fill_mark++;
          end
          tbl_key[hole] = key;
          tbl_value[hole] = value;
          tbl_occ[hole] = 1'b1;
          live_cnt++;
          r.slot = hole[SLOT_W-1:0];
          r.stored = value;
        end else begin
          r.status = ST_FULL;
          n_full++;
        end
      end
      MODE_REMOVE: begin
        n_remove++;
        if (hit >= 0) begin
          tbl_occ[hit] = 1'b0;
          live_cnt--;
          r.slot = hit[SLOT_W-1:0];
        end else begin
          r.status = ST_MISS;
          n_miss++;
        end
      end
      default: begin
        if (mode == MODE_SPARE) n_spare++;
        else n_search++;
        if (hit >= 0) begin
          r.slot = hit[SLOT_W-1:0];
          r.stored = tbl_value[hit];
        end else begin
          r.status = ST_MISS;
          n_miss++;
        end
      end
    endcase
    r.live = live_cnt[LIVE_W-1:0];
    if (live_cnt > peak_live) peak_live = live_cnt;
    return r;
  endfunction

  // driver: hold an item until taken, then advance
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        void'(pending_reqs.pop_front());
        drv_sent++;
      end
      if (start && busy) begin
      end else if (pending_reqs.size() != 0 &&
                   ((drv_sent >= 300 && drv_sent < 450) || $urandom_range(99) >= 19)) begin
        start <= 1'b1;
        in_mode <= pending_reqs[0].mode;
        in_key <= pending_reqs[0].key;
        in_value <= pending_reqs[0].value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results first, then record newly accepted items
  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (rst_n) begin
      if (out_valid) begin
        got = '{out_slot, out_status, out_stored_value, out_live_count};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%t unexpected item: slot %0d status %0d value %0d live %0d",
                     $realtime, got.slot, got.status, got.stored, got.live);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.slot !== want.slot || got.status !== want.status ||
              got.stored !== want.stored || got.live !== want.live) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%t item %0d exp/got: slot %0d/%0d st %0d/%0d val %0d/%0d live %0d/%0d",
                       $realtime, checked, want.slot, got.slot, want.status, got.status,
                       want.stored, got.stored, want.live, got.live);
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_lookup(in_mode, in_key, in_value));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic add_req(logic [MODE_W-1:0] mode, logic signed [KEY_W-1:0] key,
                         logic signed [VALUE_W-1:0] value);
    pending_reqs.push_back('{mode, key, value});
  endtask

  initial begin
    logic signed [KEY_W-1:0] key_pool[POOL_SIZE];
    logic [MODE_W-1:0] mode;
    logic signed [KEY_W-1:0] key;
    int roll;
    int rnd;
    int n;

    for (n = 0; n < POOL_SIZE; n++) key_pool[n] = $urandom;
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 0;
    key_pool[3] = -1;

    add_req(MODE_SEARCH, 0, 0);
    add_req(MODE_REMOVE, -1, 0);
    add_req(MODE_INSERT, KEY_MIN, KEY_MAX);
    add_req(MODE_INSERT, KEY_MAX, KEY_MIN);
    add_req(MODE_INSERT, 0, 0);
    add_req(MODE_INSERT, -1, -1);
    add_req(MODE_INSERT, KEY_MIN, 32'sh5555_5555);
    add_req(MODE_SEARCH, KEY_MIN, 0);
    add_req(MODE_SPARE, KEY_MAX, -1);
    add_req(MODE_REMOVE, 0, 32'sh1234_5678);
    add_req(MODE_SEARCH, 0, 0);
    add_req(MODE_REMOVE, 0, 0);
    add_req(MODE_INSERT, 42, 32'shaaaa_aaaa);
    add_req(MODE_INSERT, 7, 1);
    add_req(MODE_SEARCH, 42, 0);
    add_req(MODE_REMOVE, KEY_MIN, 0);
    add_req(MODE_REMOVE, KEY_MAX, 0);
    add_req(MODE_REMOVE, -1, 0);
    add_req(MODE_REMOVE, 42, 0);
    add_req(MODE_REMOVE, 7, 0);
    add_req(MODE_SEARCH, -1, 0);

    // fill with mostly inserts, churn, then drain with mostly removes
    for (rnd = 0; rnd < ROUNDS; rnd++) begin
      for (n = 0; n < 420; n++) begin
        roll = $urandom_range(99);
        if (n < 150)
          mode = (roll < 88) ? MODE_INSERT : (roll < 94) ? MODE_SEARCH : MODE_REMOVE;
        else if (n < 270)
          mode = (roll < 40) ? MODE_INSERT : (roll < 70) ? MODE_REMOVE : MODE_SEARCH;
        else
          mode = (roll < 78) ? MODE_REMOVE : (roll < 92) ? MODE_SEARCH : MODE_INSERT;
        if ($urandom_range(99) < 3) mode = MODE_SPARE;
        if ($urandom_range(99) < 6) key = $urandom;
        else key = key_pool[$urandom_range(POOL_SIZE - 1)];
        add_req(mode, key, $urandom);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pending_reqs.size() != 0 || expected_results.size() != 0);
    repeat (KVS_CAPACITY + 8) @(negedge clk);

    $display("Checked %0d results: %0d inserts, %0d removes, %0d searches, %0d unused-mode",
             checked, n_insert, n_remove, n_search, n_spare);
    $display("Table-full answers %0d, missing-key answers %0d, peak occupancy %0d of %0d",
             n_full, n_miss, peak_live, KVS_CAPACITY);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d items outstanding", fail_count,
               expected_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
